// ===== sv/nfpc_pkg.sv =====
// shared types, constants and helpers of the newton fractal point classifier
package nfpc_pkg;

  localparam int FRAC_BITS  = 24;
  localparam int ITERATIONS = 255;
  localparam int MAX_DEGREE = 6;
  localparam int NUM_COEFFS = MAX_DEGREE + 1;
  localparam int NUM_ROOTS  = 6;
  localparam int ITER_W     = $clog2(ITERATIONS + 1);
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;

  // squared distance bound for a radius of 0.05
  localparam logic [63:0] DIST_LIMIT = 64'(((64'd1 << (2 * FRAC_BITS)) + 64'd399) / 64'd400);
  localparam logic signed [40:0] ONE_ACC = 41'(64'd1 << FRAC_BITS);

  localparam logic [CFG_DATA_W-1:0] COEFF_RESET [NUM_COEFFS] = '{
    64'd72057594037927936, 64'd0, 64'd18302628885633695744, 64'd144115188075855872,
    64'd0, 64'd0, 64'd0
  };

  localparam logic [CFG_IDX_W-1:0] REG_DEGREE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF0 = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAST   = 4'd7;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  typedef struct packed {
    logic              action;
    logic [2:0]        root_slot;
    logic signed [31:0] point_re;
    logic signed [31:0] point_im;
  } nfpc_in_t;

  typedef struct packed {
    logic              found;
    logic [2:0]        root_index;
    logic signed [31:0] final_re;
    logic signed [31:0] final_im;
  } nfpc_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HORNER,
    ST_DEN,
    ST_DIV_RE,
    ST_DIV_IM,
    ST_UPDATE,
    ST_CHECK,
    ST_FINISH
  } nfpc_state_e;

  // saturate a wide signed value to the 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    logic signed [40:0] hi;
    logic signed [40:0] lo;
    hi = 41'sd2147483647;
    lo = -41'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  // full scale toward the sign of v, zero for zero
  function automatic logic signed [31:0] sat_sign(input logic signed [31:0] v);
    if (v[31]) begin
      sat_sign = 32'sh80000000;
    end else if (v != 32'sd0) begin
      sat_sign = 32'sh7fffffff;
    end else begin
      sat_sign = 32'sd0;
    end
  endfunction

endpackage

// ===== sv/nfpc_mul.sv =====
// registered 32x32 signed multiplier shared by all product steps
module nfpc_mul (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [63:0] p_o
);
  logic signed [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;
endmodule

// ===== sv/nfpc_div.sv =====
// bit-serial restoring divider for the saturated fixed-point quotient
module nfpc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [63:0]        mag_i,
  input  logic               neg_i,
  input  logic [63:0]        den_i,
  output logic               done_o,
  output logic signed [31:0] quo_o
);
  import nfpc_pkg::*;

  logic        busy_q;
  logic [5:0]  cnt_q;
  logic        done_q;
  logic [63:0] rem_q;
  logic [7:0]  dlo_q;
  logic [31:0] q_q;
  logic        ovf_q;
  logic        neg_q;
  logic [63:0] den_q;
  logic [64:0] trial;
  logic        take;

  assign trial = {rem_q, dlo_q[7]};
  assign take  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        // quotient of 2^32 or more saturates without iterating
        if ({8'd0, mag_i} >= {den_i, 8'd0}) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= 6'd32;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ovf_q <= {8'd0, mag_i} >= {den_i, 8'd0};
      neg_q <= neg_i;
      den_q <= den_i;
      rem_q <= {8'd0, mag_i[63:8]};
      dlo_q <= mag_i[7:0];
      q_q   <= '0;
    end else if (busy_q) begin
      rem_q <= take ? 64'(trial - {1'b0, den_q}) : trial[63:0];
      dlo_q <= {dlo_q[6:0], 1'b0};
      q_q   <= {q_q[30:0], take};
    end
  end

  always_comb begin
    if (ovf_q || q_q[31]) begin
      quo_o = neg_q ? 32'sh80000000 : 32'sh7fffffff;
    end else begin
      quo_o = neg_q ? -$signed(q_q) : $signed(q_q);
    end
  end

  assign done_o = done_q;
endmodule

// ===== sv/newton_fractal_point_classifier.sv =====
// top level: root table, coefficient registers and newton step sequencer
//
// usage
//   input channel in_valid_i / in_stall_o carries one request (nfpc_in_t).
//   action load writes point_re/point_im into root slot root_slot (slots 6
//   and 7 are ignored) and produces no result. action evaluate runs 255
//   newton steps from the start point and produces one result (nfpc_out_t)
//   on out_valid_o / out_stall_i: found, lowest matching root slot, final z.
//   a request is taken when valid is high and stall is low.
//   configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 degree, 1..7 coefficients); the user must write only while the block is idle, as the block does not enforce it.
// structure
//   each newton step evaluates p(z) and p'(z) by horner over the
//   coefficients, forms the denominator, divides both quotient parts
//   (skipped when the denominator is zero) and updates z; after the last
//   step the first d root slots are checked. all products go through one
//   registered 32x32 multiplier and both quotient parts through one
//   bit-serial divider. one request is worked at a time; in_stall_o is
//   high while busy and while a result waits in the output register.
// reset
//   degree returns to 3 and coefficients to z^3 - 2z + 2; root slots hold
//   nothing until loaded. a stalled result holds until taken.
module newton_fractal_point_classifier (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  nfpc_pkg::nfpc_in_t         in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output nfpc_pkg::nfpc_out_t        out_res_o,
  input  logic                       cfg_we_i,
  input  logic [nfpc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [nfpc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import nfpc_pkg::*;

  nfpc_state_e state_q, state_d;

  // configuration
  logic [2:0]  deg_cfg_q;
  logic [63:0] coeff_q [NUM_COEFFS];
  logic [63:0] root_q  [NUM_ROOTS];

  // sequencer counters
  logic [2:0]        deg_q;
  logic [2:0]        ci_q;
  logic [3:0]        cnt_q;
  logic [ITER_W-1:0] iter_q;
  logic [2:0]        k_q;
  logic              out_valid_q;

  // datapath
  logic signed [31:0] z_re_q, z_im_q, p_re_q, p_im_q, q_re_q, q_im_q;
  logic signed [31:0] quo_re_q, quo_im_q;
  logic signed [40:0] qacc_re_q, qacc_im_q, pacc_re_q, pacc_im_q;
  logic [63:0]        den_q, d2_q;
  logic signed [64:0] nre_q, nim_q;
  logic               found_q;
  logic [2:0]         idx_q;
  nfpc_out_t          res_q;

  // shared units
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic signed [40:0] prod_fl;
  logic               div_start, div_done, div_neg;
  logic [63:0]        div_mag;
  logic signed [64:0] div_num;
  logic signed [31:0] div_quo;

  logic [63:0]        coeff_cur;
  logic signed [32:0] dr, di;
  logic               near_box;
  logic [63:0]        d2_sum;
  logic               accept;

  nfpc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  nfpc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .mag_i   (div_mag),
    .neg_i   (div_neg),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // floor of a product to the fraction width
  assign prod_fl   = 41'(mul_p >>> FRAC_BITS);
  assign coeff_cur = coeff_q[ci_q];
  assign accept    = in_valid_i && !in_stall_o;

  // distance from the final point to the root under test
  assign dr       = 33'($signed(root_q[k_q][63:32])) - 33'(z_re_q);
  assign di       = 33'($signed(root_q[k_q][31:0])) - 33'(z_im_q);
  assign near_box = (41'(dr) < ONE_ACC) && (41'(dr) > -ONE_ACC) &&
                    (41'(di) < ONE_ACC) && (41'(di) > -ONE_ACC);
  assign d2_sum   = d2_q + 64'(mul_p);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && in_req_i.action == ACT_EVAL) begin
          state_d = ST_HORNER;
        end
      end
      ST_HORNER: begin
        if (cnt_q == 4'd8 && ci_q == deg_q) begin
          state_d = ST_DEN;
        end
      end
      ST_DEN: begin
        if (cnt_q == 4'd6) begin
          state_d = (den_q == 64'd0) ? ST_UPDATE : ST_DIV_RE;
        end
      end
      ST_DIV_RE: begin
        if (div_done) begin
          state_d = ST_DIV_IM;
        end
      end
      ST_DIV_IM: begin
        if (div_done) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (iter_q == ITER_W'(ITERATIONS - 1)) begin
          state_d = (deg_q == 3'd0) ? ST_FINISH : ST_CHECK;
        end else begin
          state_d = ST_HORNER;
        end
      end
      ST_CHECK: begin
        if (cnt_q == 4'd2 &&
            ((near_box && d2_sum < DIST_LIMIT) || k_q == 3'(deg_q - 3'd1))) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // unit controls
  always_comb begin
    mul_a     = z_re_q;
    mul_b     = q_re_q;
    div_start = 1'b0;
    div_num   = nre_q;
    case (state_q)
      ST_HORNER: begin
        case (cnt_q[2:0])
          3'd0: begin mul_a = z_re_q; mul_b = q_re_q; end
          3'd1: begin mul_a = z_im_q; mul_b = q_im_q; end
          3'd2: begin mul_a = z_re_q; mul_b = q_im_q; end
          3'd3: begin mul_a = z_im_q; mul_b = q_re_q; end
          3'd4: begin mul_a = z_re_q; mul_b = p_re_q; end
          3'd5: begin mul_a = z_im_q; mul_b = p_im_q; end
          3'd6: begin mul_a = z_re_q; mul_b = p_im_q; end
          3'd7: begin mul_a = z_im_q; mul_b = p_re_q; end
          default: begin mul_a = z_re_q; mul_b = q_re_q; end
        endcase
      end
      ST_DEN: begin
        case (cnt_q)
          4'd0: begin mul_a = q_re_q; mul_b = q_re_q; end
          4'd1: begin mul_a = q_im_q; mul_b = q_im_q; end
          4'd2: begin mul_a = p_re_q; mul_b = q_re_q; end
          4'd3: begin mul_a = p_im_q; mul_b = q_im_q; end
          4'd4: begin mul_a = p_im_q; mul_b = q_re_q; end
          4'd5: begin mul_a = p_re_q; mul_b = q_im_q; end
          default: begin mul_a = q_re_q; mul_b = q_re_q; end
        endcase
      end
      ST_DIV_RE: begin
        div_start = (cnt_q == 4'd0);
        div_num   = nre_q;
      end
      ST_DIV_IM: begin
        div_start = (cnt_q == 4'd0);
        div_num   = nim_q;
      end
      ST_CHECK: begin
        // out-of-box distances are never used, so the low 32 bits suffice
        mul_a = (cnt_q == 4'd0) ? dr[31:0] : di[31:0];
        mul_b = mul_a;
      end
      default: begin
        mul_a = z_re_q;
        mul_b = q_re_q;
      end
    endcase
  end

  assign div_neg = div_num[64];
  assign div_mag = div_neg ? 64'(-div_num) : div_num[63:0];

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      deg_cfg_q   <= 3'd3;
      coeff_q     <= COEFF_RESET;
      cnt_q       <= '0;
      ci_q        <= '0;
      iter_q      <= '0;
      k_q         <= '0;
      deg_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_DEGREE) begin
          deg_cfg_q <= cfg_data_i[2:0];
        end else if (cfg_idx_i <= REG_LAST) begin
          coeff_q[3'(cfg_idx_i - REG_COEFF0)] <= cfg_data_i;
        end
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept && in_req_i.action == ACT_EVAL) begin
            deg_q  <= (deg_cfg_q > 3'(MAX_DEGREE)) ? 3'(MAX_DEGREE) : deg_cfg_q;
            cnt_q  <= '0;
            ci_q   <= '0;
            iter_q <= '0;
          end
        end
        ST_HORNER: begin
          if (cnt_q == 4'd8) begin
            cnt_q <= '0;
            if (ci_q != deg_q) begin
              ci_q <= ci_q + 3'd1;
            end
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        ST_DEN: begin
          cnt_q <= (cnt_q == 4'd6) ? 4'd0 : cnt_q + 4'd1;
        end
        ST_DIV_RE, ST_DIV_IM: begin
          cnt_q <= div_done ? 4'd0 : 4'd1;
        end
        ST_UPDATE: begin
          iter_q <= iter_q + ITER_W'(1);
          ci_q   <= '0;
          cnt_q  <= '0;
          k_q    <= '0;
        end
        ST_CHECK: begin
          if (cnt_q == 4'd2) begin
            cnt_q <= '0;
            k_q   <= k_q + 3'd1;
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        ST_FINISH: out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_req_i.action == ACT_LOAD) begin
            if (in_req_i.root_slot < 3'(NUM_ROOTS)) begin
              root_q[in_req_i.root_slot] <= {in_req_i.point_re, in_req_i.point_im};
            end
          end else begin
            z_re_q <= in_req_i.point_re;
            z_im_q <= in_req_i.point_im;
            p_re_q <= '0;
            p_im_q <= '0;
            q_re_q <= '0;
            q_im_q <= '0;
          end
        end
      end
      ST_HORNER: begin
        // q takes z*q + p, p takes z*p + c, both from the old p
        case (cnt_q)
          4'd0: begin
            qacc_re_q <= 41'(p_re_q);
            qacc_im_q <= 41'(p_im_q);
            pacc_re_q <= 41'($signed(coeff_cur[63:32]));
            pacc_im_q <= 41'($signed(coeff_cur[31:0]));
          end
          4'd1: qacc_re_q <= qacc_re_q + prod_fl;
          4'd2: qacc_re_q <= qacc_re_q - prod_fl;
          4'd3: qacc_im_q <= qacc_im_q + prod_fl;
          4'd4: qacc_im_q <= qacc_im_q + prod_fl;
          4'd5: pacc_re_q <= pacc_re_q + prod_fl;
          4'd6: pacc_re_q <= pacc_re_q - prod_fl;
          4'd7: pacc_im_q <= pacc_im_q + prod_fl;
          4'd8: begin
            q_re_q <= sat32(qacc_re_q);
            q_im_q <= sat32(qacc_im_q);
            p_re_q <= sat32(pacc_re_q);
            p_im_q <= sat32(pacc_im_q + prod_fl);
          end
          default: ;
        endcase
      end
      ST_DEN: begin
        case (cnt_q)
          4'd1: den_q <= 64'(mul_p);
          4'd2: den_q <= den_q + 64'(mul_p);
          4'd3: nre_q <= 65'(mul_p);
          4'd4: nre_q <= nre_q + 65'(mul_p);
          4'd5: nim_q <= 65'(mul_p);
          4'd6: begin
            nim_q    <= nim_q - 65'(mul_p);
            quo_re_q <= sat_sign(p_re_q);
            quo_im_q <= sat_sign(p_im_q);
          end
          default: ;
        endcase
      end
      ST_DIV_RE: begin
        if (div_done) begin
          quo_re_q <= div_quo;
        end
      end
      ST_DIV_IM: begin
        if (div_done) begin
          quo_im_q <= div_quo;
        end
      end
      ST_UPDATE: begin
        z_re_q  <= sat32(41'(33'(z_re_q) - 33'(quo_re_q)));
        z_im_q  <= sat32(41'(33'(z_im_q) - 33'(quo_im_q)));
        p_re_q  <= '0;
        p_im_q  <= '0;
        q_re_q  <= '0;
        q_im_q  <= '0;
        found_q <= 1'b0;
        idx_q   <= '0;
      end
      ST_CHECK: begin
        if (cnt_q == 4'd1) begin
          d2_q <= 64'(mul_p);
        end else if (cnt_q == 4'd2 && near_box && d2_sum < DIST_LIMIT) begin
          found_q <= 1'b1;
          idx_q   <= k_q;
        end
      end
      ST_FINISH: begin
        res_q.found      <= found_q;
        res_q.root_index <= idx_q;
        res_q.final_re   <= z_re_q;
        res_q.final_im   <= z_im_q;
      end
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE) || out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;
endmodule

// ===== sv/nfpc_checker.sv =====
// port-level checks of the classifier, bound to the top level
module nfpc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input nfpc_pkg::nfpc_in_t  in_req_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input nfpc_pkg::nfpc_out_t out_res_o
);
  import nfpc_pkg::*;

  // a pending result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // no new request while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request taken while result pending");

  // an evaluate request makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_req_i.action == ACT_EVAL |=> in_stall_o)
    else $error("not busy after evaluate request");

  // no match reports slot zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_res_o.found |-> out_res_o.root_index == 3'd0)
    else $error("root index set without match");
endmodule

bind newton_fractal_point_classifier nfpc_checker u_nfpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_res_o   (out_res_o)
);
